### hdl/assert_macros.svh
// Assertion macros shared by the RTL; the synthesis build gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BFHA_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define BFHA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BFHA_ASSERT_ALWAYS(lbl, expr)
`define BFHA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg
// Types and constants shared by the best-fit allocator cells and top level.
// ----------------------------------------------------------------------------
package bfha_pkg;

    localparam int ADDR_W = 16;
    localparam int WIDE_W = 17;
    localparam int ARITH_W = 18;
    localparam int IDX_W = 8;   // slot index, up to 256 slots
    localparam int POS_W = 9;   // insert position, up to the slot count

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_HEAP  = 2'd1,
        ST_BAD_ADDR = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } state_t;

    typedef enum logic [1:0] {
        FOP_HOLD,
        FOP_WRITE,
        FOP_INSERT,
        FOP_REMOVE
    } free_op_t;

    typedef enum logic [1:0] {
        UOP_HOLD,
        UOP_SET,
        UOP_CLEAR
    } used_op_t;

    typedef struct packed {
        free_op_t            op;
        logic [POS_W-1:0]    idx;
        logic [ADDR_W-1:0]   start;
        logic [ADDR_W-1:0]   size;
    } free_cmd_t;

    typedef struct packed {
        used_op_t            op;
        logic [IDX_W-1:0]    idx;
        logic [ADDR_W-1:0]   start;
        logic [ADDR_W-1:0]   size;
    } used_cmd_t;

    // Best fit and last block at or below the freed header, carried cell to cell
    typedef struct packed {
        logic                fit_found;
        logic [IDX_W-1:0]    fit_idx;
        logic [ADDR_W-1:0]   fit_start;
        logic [ADDR_W-1:0]   fit_size;
        logic                le_found;
        logic [IDX_W-1:0]    le_idx;
        logic [ADDR_W-1:0]   le_start;
        logic [ADDR_W-1:0]   le_size;
    } free_scan_t;

    // First empty slot and the slot holding the freed address
    typedef struct packed {
        logic                slot_found;
        logic [IDX_W-1:0]    slot_idx;
        logic                match_found;
        logic [IDX_W-1:0]    match_idx;
        logic [ADDR_W-1:0]   match_size;
    } used_scan_t;

endpackage

### hdl/best_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// Best-fit allocate/free over a bounded heap, kept in rows of list cells.
// ----------------------------------------------------------------------------
// Request word on s_*: s_tuser is the action (0 allocate, 1 free), s_tdata
// carries the request size and the address to free. Every request yields one
// result word on m_*: granted address, status, heap size and free bytes.
// A request is taken only while the block is idle. The scan wave then walks
// both cell rows one cell per cycle, followed by an update, and the block is
// ready again in the cycle after the update. The result sits in an output
// register, so the next request is accepted while the previous result waits;
// the update holds only when that register is still full. A stalled receiver
// thus stops the block after at most one request in flight. Reset empties
// both tables, zeroes the heap top and the free byte count; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module best_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 32,
    parameter int FREE_SLOTS   = 64,
    parameter int USED_SLOTS   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // request_bytes[15:0], free_address[31:16]
    input  logic        s_tuser,   // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // data_address[15:0], status[17:16],
                                   // segment_bytes[34:18], free_bytes[51:35]
);
    import bfha_pkg::*;

    localparam int SCAN_LEN = (FREE_SLOTS > USED_SLOTS) ? FREE_SLOTS : USED_SLOTS;
    localparam int SCNT_W   = $clog2(SCAN_LEN);
    localparam int CNT_W    = $clog2(FREE_SLOTS + 1);
    localparam logic [ARITH_W-1:0] HDR  = ARITH_W'(HEADER_BYTES);
    localparam logic [ARITH_W-1:0] HEAP = ARITH_W'(HEAP_BYTES);
    localparam logic [ARITH_W-1:0] ADDR_MAX = ARITH_W'(65535);
    localparam logic [SCNT_W-1:0] SCAN_LAST = SCNT_W'(SCAN_LEN - 1);
    localparam logic [CNT_W-1:0] FREE_CAP = CNT_W'(FREE_SLOTS);

    state_t             state_reg, state_next;
    logic [SCNT_W-1:0]  scnt_reg, scnt_next;
    logic               action_reg;
    logic [ADDR_W-1:0]  req_reg;
    logic [ADDR_W-1:0]  faddr_reg;
    logic [ADDR_W-1:0]  hdr_addr;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [WIDE_W-1:0]  top_reg, top_next;
    logic [WIDE_W-1:0]  sum_reg, sum_next;
    logic               mvalid_reg, mvalid_next;
    logic [ADDR_W-1:0]  maddr_reg, maddr_next;
    status_t            mstat_reg, mstat_next;
    logic               exec_go;
    logic               in_take;

    free_cmd_t          fcmd;
    used_cmd_t          ucmd;
    free_scan_t         fscan [FREE_SLOTS+1];
    used_scan_t         uscan [USED_SLOTS+1];
    logic [ADDR_W-1:0]  fstart [FREE_SLOTS];
    logic [ADDR_W-1:0]  fsize  [FREE_SLOTS];
    free_scan_t         fres;
    used_scan_t         ures;

    logic [ARITH_W-1:0] grow_top;
    logic [ARITH_W-1:0] blk_bytes;
    logic [ARITH_W-1:0] le_end;
    logic [ARITH_W-1:0] new_end;
    logic [POS_W-1:0]   ins_pos;

    assign hdr_addr = faddr_reg - ADDR_W'(HEADER_BYTES);
    assign fscan[0] = '0;
    assign uscan[0] = '0;
    assign fres     = fscan[FREE_SLOTS];
    assign ures     = uscan[USED_SLOTS];

    generate
        for (genvar i = 0; i < FREE_SLOTS; i++)
        begin : g_free
            logic [ADDR_W-1:0] l_start, l_size, r_start, r_size;
            logic              cell_valid;
            if (i == 0)
            begin : g_left_edge
                assign l_start = '0;
                assign l_size  = '0;
            end
            else
            begin : g_left
                assign l_start = fstart[i-1];
                assign l_size  = fsize[i-1];
            end
            if (i == FREE_SLOTS - 1)
            begin : g_right_edge
                assign r_start = '0;
                assign r_size  = '0;
            end
            else
            begin : g_right
                assign r_start = fstart[i+1];
                assign r_size  = fsize[i+1];
            end
            assign cell_valid = (CNT_W'(i) < count_reg);

            bfha_free_cell #(.IDX(i)) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .valid       (cell_valid),
                .cmd         (fcmd),
                .left_start  (l_start),
                .left_size   (l_size),
                .right_start (r_start),
                .right_size  (r_size),
                .req_bytes   (req_reg),
                .hdr_addr    (hdr_addr),
                .scan_in     (fscan[i]),
                .start       (fstart[i]),
                .size        (fsize[i]),
                .scan_out    (fscan[i+1])
            );
        end

        for (genvar j = 0; j < USED_SLOTS; j++)
        begin : g_used
            bfha_used_cell #(.IDX(j)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (ucmd),
                .addr     (faddr_reg),
                .scan_in  (uscan[j]),
                .scan_out (uscan[j+1])
            );
        end
    endgenerate

    assign exec_go = (state_reg == ST_EXEC) && (!mvalid_reg || m_tready);
    assign in_take = s_tvalid && s_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        scnt_next  = scnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scnt_next = '0;
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scnt_next = scnt_reg + 1'b1;
                if (scnt_reg == SCAN_LAST)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
    end

    // table update from the scan results
    always_comb
    begin
        fcmd        = '{op: FOP_HOLD, idx: '0, start: '0, size: '0};
        ucmd        = '{op: UOP_HOLD, idx: '0, start: '0, size: '0};
        count_next  = count_reg;
        top_next    = top_reg;
        sum_next    = sum_reg;
        maddr_next  = '0;
        mstat_next  = ST_OK;
        grow_top    = ARITH_W'(top_reg) + HDR + ARITH_W'(req_reg);
        blk_bytes   = '0;
        le_end      = ARITH_W'(fres.le_start) + HDR + ARITH_W'(fres.le_size);
        new_end     = ARITH_W'(hdr_addr) + HDR + ARITH_W'(ures.match_size);
        ins_pos     = fres.le_found ? (POS_W'(fres.le_idx) + 1'b1) : '0;

        if (!action_reg)
        begin
            if (!ures.slot_found)
            begin
                mstat_next = ST_FULL;
            end
            else if (!fres.fit_found)
            begin
                if (grow_top > HEAP || (ARITH_W'(top_reg) + HDR) > ADDR_MAX)
                begin
                    mstat_next = ST_NO_HEAP;
                end
                else
                begin
                    top_next   = grow_top[WIDE_W-1:0];
                    maddr_next = top_reg[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
                    ucmd       = '{op: UOP_SET, idx: ures.slot_idx,
                                   start: maddr_next, size: req_reg};
                end
            end
            else
            begin
                maddr_next = fres.fit_start + ADDR_W'(HEADER_BYTES);
                if (ARITH_W'(fres.fit_size) <= ARITH_W'(req_reg) + (HDR << 1))
                begin
                    // take the whole block
                    blk_bytes  = HDR + ARITH_W'(fres.fit_size);
                    sum_next   = WIDE_W'(ARITH_W'(sum_reg) - blk_bytes);
                    count_next = count_reg - 1'b1;
                    fcmd       = '{op: FOP_REMOVE, idx: POS_W'(fres.fit_idx),
                                   start: '0, size: '0};
                    ucmd       = '{op: UOP_SET, idx: ures.slot_idx,
                                   start: maddr_next, size: fres.fit_size};
                end
                else
                begin
                    // split: remainder stays in the same position
                    blk_bytes  = HDR + ARITH_W'(req_reg);
                    sum_next   = WIDE_W'(ARITH_W'(sum_reg) - blk_bytes);
                    fcmd       = '{op: FOP_WRITE, idx: POS_W'(fres.fit_idx),
                                   start: ADDR_W'(ARITH_W'(fres.fit_start) + blk_bytes),
                                   size: ADDR_W'(ARITH_W'(fres.fit_size) - blk_bytes)};
                    ucmd       = '{op: UOP_SET, idx: ures.slot_idx,
                                   start: maddr_next, size: req_reg};
                end
            end
        end
        else
        begin
            blk_bytes = HDR + ARITH_W'(ures.match_size);
            if (!ures.match_found)
            begin
                mstat_next = ST_BAD_ADDR;
            end
            else if (fres.le_found && le_end == ARITH_W'(hdr_addr))
            begin
                // merge into the block before
                sum_next = WIDE_W'(ARITH_W'(sum_reg) + blk_bytes);
                fcmd     = '{op: FOP_WRITE, idx: POS_W'(fres.le_idx), start: fres.le_start,
                             size: ADDR_W'(ARITH_W'(fres.le_size) + blk_bytes)};
                ucmd     = '{op: UOP_CLEAR, idx: ures.match_idx, start: '0, size: '0};
            end
            else if (!fres.le_found && count_reg != '0
                     && new_end == ARITH_W'(fstart[0]))
            begin
                // absorb the first block
                sum_next = WIDE_W'(ARITH_W'(sum_reg) + blk_bytes);
                fcmd     = '{op: FOP_WRITE, idx: '0, start: hdr_addr,
                             size: ADDR_W'(ARITH_W'(fsize[0]) + blk_bytes)};
                ucmd     = '{op: UOP_CLEAR, idx: ures.match_idx, start: '0, size: '0};
            end
            else if (count_reg >= FREE_CAP)
            begin
                mstat_next = ST_FULL;
            end
            else
            begin
                sum_next   = WIDE_W'(ARITH_W'(sum_reg) + blk_bytes);
                count_next = count_reg + 1'b1;
                fcmd       = '{op: FOP_INSERT, idx: ins_pos, start: hdr_addr,
                               size: ures.match_size};
                ucmd       = '{op: UOP_CLEAR, idx: ures.match_idx, start: '0, size: '0};
            end
        end

        if (!exec_go)
        begin
            fcmd.op    = FOP_HOLD;
            ucmd.op    = UOP_HOLD;
            count_next = count_reg;
            top_next   = top_reg;
            sum_next   = sum_reg;
        end
    end

    always_comb
    begin
        mvalid_next = mvalid_reg;
        if (exec_go)
        begin
            mvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= s_tuser;
            req_reg    <= s_tdata[15:0];
            faddr_reg  <= s_tdata[31:16];
        end
        if (exec_go)
        begin
            maddr_reg <= maddr_next;
            mstat_reg <= mstat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            scnt_reg   <= '0;
            count_reg  <= '0;
            top_reg    <= '0;
            sum_reg    <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            scnt_reg   <= scnt_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            sum_reg    <= sum_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // top and free byte count are reported as they stand after the update
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {4'b0, sum_reg, top_reg, mstat_reg, maddr_reg};

    `BFHA_ASSERT_ALWAYS(a_count_cap, count_reg <= FREE_CAP)
    `BFHA_ASSERT_ALWAYS(a_top_cap, ARITH_W'(top_reg) <= HEAP)
    `BFHA_ASSERT_NEXT(a_sum_only_exec, !exec_go, $stable(sum_reg) && $stable(top_reg))
    `BFHA_ASSERT_NEXT(a_exec_result, exec_go, mvalid_reg && state_reg == ST_IDLE)

endmodule

### hdl/bfha_free_cell.sv
// ----------------------------------------------------------------------------
// bfha_free_cell
// One entry of the address-sorted free list with its scan stage.
// ----------------------------------------------------------------------------
module bfha_free_cell #(
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid,
    input  bfha_pkg::free_cmd_t         cmd,
    input  logic [15:0]                 left_start,
    input  logic [15:0]                 left_size,
    input  logic [15:0]                 right_start,
    input  logic [15:0]                 right_size,
    input  logic [15:0]                 req_bytes,
    input  logic [15:0]                 hdr_addr,
    input  bfha_pkg::free_scan_t        scan_in,
    output logic [15:0]                 start,
    output logic [15:0]                 size,
    output bfha_pkg::free_scan_t        scan_out
);
    import bfha_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [ADDR_W-1:0] start_reg, start_next;
    logic [ADDR_W-1:0] size_reg, size_next;
    free_scan_t        scan_reg, scan_next;
    logic              fits;

    always_comb
    begin
        start_next = start_reg;
        size_next  = size_reg;
        case (cmd.op)
            FOP_WRITE:
            begin
                if (cmd.idx == MY_POS)
                begin
                    start_next = cmd.start;
                    size_next  = cmd.size;
                end
            end
            FOP_INSERT:
            begin
                if (MY_POS > cmd.idx)
                begin
                    start_next = left_start;
                    size_next  = left_size;
                end
                else if (MY_POS == cmd.idx)
                begin
                    start_next = cmd.start;
                    size_next  = cmd.size;
                end
            end
            FOP_REMOVE:
            begin
                if (MY_POS >= cmd.idx)
                begin
                    start_next = right_start;
                    size_next  = right_size;
                end
            end
            default:
            begin
                start_next = start_reg;
            end
        endcase
    end

    always_comb
    begin
        scan_next = scan_in;
        fits = valid && (size_reg >= req_bytes);
        // strict compare keeps the lower address on ties
        if (fits && (!scan_in.fit_found || size_reg < scan_in.fit_size))
        begin
            scan_next.fit_found = 1'b1;
            scan_next.fit_idx   = IDX_W'(IDX);
            scan_next.fit_start = start_reg;
            scan_next.fit_size  = size_reg;
        end
        if (valid && start_reg <= hdr_addr)
        begin
            scan_next.le_found = 1'b1;
            scan_next.le_idx   = IDX_W'(IDX);
            scan_next.le_start = start_reg;
            scan_next.le_size  = size_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        size_reg  <= size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign start    = start_reg;
    assign size     = size_reg;
    assign scan_out = scan_reg;

endmodule

### hdl/bfha_used_cell.sv
// ----------------------------------------------------------------------------
// bfha_used_cell
// One entry of the allocated-block table with its scan stage.
// ----------------------------------------------------------------------------
module bfha_used_cell #(
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bfha_pkg::used_cmd_t         cmd,
    input  logic [15:0]                 addr,
    input  bfha_pkg::used_scan_t        scan_in,
    output bfha_pkg::used_scan_t        scan_out
);
    import bfha_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] size_reg;
    used_scan_t        scan_reg, scan_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.idx == MY_IDX)
        begin
            case (cmd.op)
                UOP_SET:   valid_next = 1'b1;
                UOP_CLEAR: valid_next = 1'b0;
                default:   valid_next = valid_reg;
            endcase
        end
    end

    always_comb
    begin
        scan_next = scan_in;
        if (!scan_in.slot_found && !valid_reg)
        begin
            scan_next.slot_found = 1'b1;
            scan_next.slot_idx   = MY_IDX;
        end
        if (!scan_in.match_found && valid_reg && start_reg == addr)
        begin
            scan_next.match_found = 1'b1;
            scan_next.match_idx   = MY_IDX;
            scan_next.match_size  = size_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == UOP_SET && cmd.idx == MY_IDX)
        begin
            start_reg <= cmd.start;
            size_reg  <= cmd.size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            scan_reg  <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule
